@@ design/f2p_pkg.sv @@
// f2p_pkg: shared constants, register codes and the decode word type
// for the float32 to posit converter; no dependencies
package f2p_pkg;

   // ieee single precision layout
   localparam int FP_TOTAL_BITS = 32;
   localparam int FP_EXP_BITS   = 8;
   localparam int FP_FRAC_BITS  = 23;
   localparam int FP_BIAS       = 127;

   // posit configuration limits
   localparam int DEFAULT_MAX_POSIT_WIDTH = 32;
   localparam int MIN_POSIT_WIDTH         = 2;
   localparam int RESET_POSIT_WIDTH       = 8;
   localparam int ES_LIMIT                = 4;

   // register widths
   localparam int WIDTH_REG_W = 6;
   localparam int ES_REG_W    = 3;
   localparam int CSR_DATA_W  = 6;
   localparam int CSR_INDEX_W = 1;

   // tail holds up to ES_LIMIT exponent bits followed directly by the fraction
   localparam int ES_FIELD_W = ES_LIMIT;
   localparam int TAIL_W     = ES_FIELD_W + FP_FRAC_BITS;

   // unbiased scale and regime length arithmetic
   localparam int SCALE_W = FP_EXP_BITS + 1;
   localparam int RLEN_W  = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POSIT_WIDTH   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPONENT_SIZE = 1'd1;

   // decoded float, handed from decode to pack
   typedef struct packed {
      logic                sign;
      logic                zero;
      logic                special;   // infinity or nan
      logic                sat_pos;   // regime too long, large value
      logic                sat_neg;   // regime too long, small value
      logic                reg_neg;   // negative regime
      logic [RLEN_W-1:0]   rlen;
      logic [TAIL_W-1:0]   tail;      // exponent bits then fraction, top aligned
   } f2p_dec_type;

endpackage

@@ design/f2p_decode.sv @@
// f2p_decode: splits a float32 word into sign, scale, regime and tail
// depends on f2p_pkg
module f2p_decode import f2p_pkg::*; (
   input  logic [FP_TOTAL_BITS-1:0] float_bits,
   input  logic [WIDTH_REG_W-1:0]   posit_width,
   input  logic [ES_REG_W-1:0]      exponent_size,
   output f2p_dec_type              dec
);

   logic [FP_EXP_BITS-1:0]   biased_exp;
   logic signed [SCALE_W-1:0] scale;
   logic signed [SCALE_W-1:0] regime;
   logic signed [SCALE_W-1:0] rlen_s;
   logic [TAIL_W-1:0]        tail_al;
   logic [RLEN_W-1:0]        rlen;
   logic [RLEN_W-1:0]        width_ext;
   logic [ES_REG_W-1:0]      expo_shift;

   assign biased_exp = float_bits[FP_TOTAL_BITS-2 -: FP_EXP_BITS];
   assign scale      = $signed({1'b0, biased_exp}) - $signed(SCALE_W'(FP_BIAS));

   // floor division by two to the es
   assign regime = scale >>> exponent_size;
   assign rlen_s = regime[SCALE_W-1] ? (SCALE_W'(1) - regime) : (regime + SCALE_W'(2));
   assign rlen   = rlen_s[RLEN_W-1:0];

   // low es bits of the scale then the fraction, shifted up to the top of the tail
   assign expo_shift = ES_REG_W'(ES_FIELD_W) - exponent_size;
   assign tail_al    = TAIL_W'({scale[ES_FIELD_W-1:0], float_bits[FP_FRAC_BITS-1:0]}
                               << expo_shift);

   assign width_ext = RLEN_W'(posit_width);

   always_comb begin
      dec.sign    = float_bits[FP_TOTAL_BITS-1];
      dec.zero    = (float_bits[FP_TOTAL_BITS-2:0] == '0);
      dec.special = &biased_exp;
      dec.reg_neg = regime[SCALE_W-1];
      dec.sat_pos = !regime[SCALE_W-1] && (rlen > width_ext);
      dec.sat_neg = regime[SCALE_W-1] && (rlen >= width_ext);
      dec.rlen    = rlen;
      dec.tail    = tail_al;
   end

endmodule

@@ design/f2p_pack.sv @@
// f2p_pack: lays regime and tail into a bit string, cuts it to the posit
// width and rounds; depends on f2p_pkg
module f2p_pack import f2p_pkg::*; #(
   parameter int MAX_POSIT_WIDTH = DEFAULT_MAX_POSIT_WIDTH
) (
   input  f2p_dec_type              dec,
   input  logic [WIDTH_REG_W-1:0]   posit_width,
   output logic [FP_TOTAL_BITS-1:0] posit_bits
);

   localparam int XW = MAX_POSIT_WIDTH + TAIL_W;
   localparam int SW = $clog2(XW + 1);
   localparam logic [XW-1:0] ALL_ONES = '1;
   localparam logic [XW-1:0] ONE_TOP  = {1'b1, {(XW-1){1'b0}}};
   localparam logic [FP_TOTAL_BITS-1:0] WORD_ONES = '1;

   logic [SW-1:0]              rl;
   logic [SW-1:0]              drop;
   logic [XW-1:0]              regime_bits;
   logic [XW-1:0]              tail_bits;
   logic [XW-1:0]              str;
   logic [XW-1:0]              body_full;
   logic [XW-1:0]              sticky_mask;
   logic [MAX_POSIT_WIDTH-1:0] body;
   logic                       guard;
   logic                       sticky;
   logic [FP_TOTAL_BITS-1:0]   nmask;
   logic [FP_TOTAL_BITS-1:0]   sign_bit;
   logic [FP_TOTAL_BITS-1:0]   rounded;

   assign rl = SW'(dec.rlen);

   // regime: run of ones ended by a zero, or run of zeros ended by a one
   assign regime_bits = dec.reg_neg ? (ONE_TOP >> (rl - 1'b1))
                                    : ~(ALL_ONES >> (rl - 1'b1));
   assign tail_bits   = {dec.tail, {MAX_POSIT_WIDTH{1'b0}}} >> rl;
   assign str         = regime_bits | tail_bits;

   // keep the top n-1 bits, guard next, sticky below
   assign drop        = SW'(XW) - SW'(posit_width);
   assign body_full   = str >> drop;
   assign guard       = body_full[0];
   assign body        = MAX_POSIT_WIDTH'(body_full >> 1);
   assign sticky_mask = ~(ALL_ONES << drop);
   assign sticky      = |(str & sticky_mask);

   assign nmask    = ~(WORD_ONES << posit_width);
   assign sign_bit = FP_TOTAL_BITS'(dec.sign) << (posit_width - 1'b1);
   assign rounded  = FP_TOTAL_BITS'(body) + FP_TOTAL_BITS'(guard & sticky);

   always_comb begin
      if (dec.zero) begin
         posit_bits = '0;
      end else if (dec.special) begin
         posit_bits = nmask;
      end else if (dec.sat_pos) begin
         posit_bits = (nmask >> 1) | sign_bit;
      end else if (dec.sat_neg) begin
         posit_bits = (FP_TOTAL_BITS'(1) | sign_bit) & nmask;
      end else begin
         posit_bits = (rounded | sign_bit) & nmask;
      end
   end

endmodule

@@ design/float32_to_posit_converter_unit.sv @@
// float32_to_posit_converter_unit: top level with request, result and
// register stages; depends on f2p_pkg, f2p_decode and f2p_pack
//
// converts one ieee single precision word to a posit of posit_width bits with
// an exponent_size bit exponent field. a word is taken at every clock edge
// where start is high and busy is low; busy is only raised during reset, so a
// new word may follow in every cycle. each result is on rsp_posit_bits with
// rsp_valid high for a single cycle once its word moves on from the request
// register, and there is no way to hold it. a word passes the request
// register and the result register, with decode and pack in one pass
// between them. zero gives 0, infinity and nan give all ones, subnormals
// count as scale -127 with a hidden one, and a regime that does not fit gives
// maxpos or minpos. the sign is ored into the top posit bit (sign-magnitude).
// rounding increments only when guard and sticky are both set, so an exact
// tie rounds down. registers are written with no handshake and should only
// change while no conversion is in flight; widths below 2 act as 2, widths
// above MAX_POSIT_WIDTH act as MAX_POSIT_WIDTH, exponent sizes 5 to 7 act as
// 4 and only the low 3 bits of a written exponent size are kept. unused upper
// result bits read zero.
module float32_to_posit_converter_unit import f2p_pkg::*; #(
   parameter int MAX_POSIT_WIDTH = DEFAULT_MAX_POSIT_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [FP_TOTAL_BITS-1:0] req_float_bits,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   output logic                     rsp_valid,
   output logic [FP_TOTAL_BITS-1:0] rsp_posit_bits
);

   // configuration, held already clamped to its legal range
   logic [WIDTH_REG_W-1:0]   posit_width_ff, posit_width_in;
   logic [ES_REG_W-1:0]      exponent_size_ff, exponent_size_in;

   // request stage
   logic                     req_valid_ff, req_valid_in;
   logic [FP_TOTAL_BITS-1:0] req_word_ff, req_word_in;

   // result stage
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FP_TOTAL_BITS-1:0] rsp_word_ff, rsp_word_in;

   f2p_dec_type              dec;
   logic [FP_TOTAL_BITS-1:0] posit_word;
   logic                     accept;

   // no stall inside the block, only reset holds off requests
   assign busy   = reset;
   assign accept = start && !busy;

   // register writes with range clamping
   always_comb begin
      posit_width_in   = posit_width_ff;
      exponent_size_in = exponent_size_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_POSIT_WIDTH: begin
               if (csr_write_data < WIDTH_REG_W'(MIN_POSIT_WIDTH)) begin
                  posit_width_in = WIDTH_REG_W'(MIN_POSIT_WIDTH);
               end else if (csr_write_data > WIDTH_REG_W'(MAX_POSIT_WIDTH)) begin
                  posit_width_in = WIDTH_REG_W'(MAX_POSIT_WIDTH);
               end else begin
                  posit_width_in = WIDTH_REG_W'(csr_write_data);
               end
            end
            CSR_EXPONENT_SIZE: begin
               if (csr_write_data[ES_REG_W-1:0] > ES_REG_W'(ES_LIMIT)) begin
                  exponent_size_in = ES_REG_W'(ES_LIMIT);
               end else begin
                  exponent_size_in = csr_write_data[ES_REG_W-1:0];
               end
            end
            default: begin
               posit_width_in   = posit_width_ff;
               exponent_size_in = exponent_size_ff;
            end
         endcase
      end
   end

   // stage inputs
   assign req_valid_in = accept;
   assign req_word_in  = accept ? req_float_bits : req_word_ff;
   assign rsp_valid_in = req_valid_ff;
   assign rsp_word_in  = req_valid_ff ? posit_word : rsp_word_ff;

   f2p_decode u_decode (
      .float_bits    (req_word_ff),
      .posit_width   (posit_width_ff),
      .exponent_size (exponent_size_ff),
      .dec           (dec)
   );

   f2p_pack #(
      .MAX_POSIT_WIDTH (MAX_POSIT_WIDTH)
   ) u_pack (
      .dec         (dec),
      .posit_width (posit_width_ff),
      .posit_bits  (posit_word)
   );

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         posit_width_ff   <= WIDTH_REG_W'(RESET_POSIT_WIDTH);
         exponent_size_ff <= '0;
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         posit_width_ff   <= posit_width_in;
         exponent_size_ff <= exponent_size_in;
         req_valid_ff     <= req_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload words
   always_ff @(posedge clock) begin
      req_word_ff <= req_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_posit_bits = rsp_word_ff;

`ifndef SYNTHESIS
   // every result traces back to an earlier request through the request and result registers
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("result without a request two cycles earlier");

   // every word taken gives a result after the request and result registers
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("request lost in the pipeline");

   // bits above the configured width stay clear
   a_upper_bits_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_posit_bits >> posit_width_ff) == '0))
      else $error("result has bits above the posit width");

   // stored configuration always within its clamped range
   a_cfg_in_range: assert property (@(posedge clock) disable iff (reset)
      (posit_width_ff >= WIDTH_REG_W'(MIN_POSIT_WIDTH)) &&
      (posit_width_ff <= WIDTH_REG_W'(MAX_POSIT_WIDTH)) &&
      (exponent_size_ff <= ES_REG_W'(ES_LIMIT)))
      else $error("configuration register out of range");
`endif

endmodule
